// File: rtl/fsblt_pkg.sv
package fsblt_pkg;

  // register field widths
  localparam int START_W = 64;
  localparam int LBB_W   = 17;
  localparam int FBB_W   = 21;
  localparam int CLASS_W = 3;
  localparam int BLK_W   = 64;

  // apb register map, one 64-bit register every 8 bytes
  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;
  localparam logic [2:0] REG_START_SECTORS = 3'd0;
  localparam logic [2:0] REG_LBB           = 3'd1;
  localparam logic [2:0] REG_FBB           = 3'd2;
  localparam logic [2:0] REG_DEV_CLASS     = 3'd3;
  localparam logic [2:0] REG_RAW_WRITE     = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REFUSED  = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // device classes that may be translated
  localparam logic [CLASS_W-1:0] CLASS_PLAIN = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_LOOP  = 3'd3;

  // 512-byte sector is 2^9
  localparam int SECTOR_LOG2 = 9;

  // shared adder, wide enough for doubled product plus a 64-bit block
  localparam int ADD_W = 66;
  localparam int CNT_W = 7;

  localparam logic [CNT_W-1:0] RATIO_STEPS = CNT_W'(FBB_W);
  localparam logic [CNT_W-1:0] START_STEPS = CNT_W'(START_W);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RATIO,
    S_RATIO_CHK,
    S_START,
    S_SCALE,
    S_MUL,
    S_SUM,
    S_DONE
  } state_t;

endpackage

// File: rtl/fs_block_to_lba_translator_core.sv
// filesystem block to device lba translator
//
// input channel: block_num with in_valid / in_stall. a transaction is taken
// when in_valid is high and in_stall low; in_stall stays high while an item
// is being worked on, so one item is in flight at a time.
// output channel: lba and status with out_valid / out_stall, held in an
// output register until the receiver takes the transaction. while out_stall
// holds a result, the next item may already be accepted and computed; it
// waits in its final state until the output register frees up.
// configuration: apb port, 64-bit registers at byte address 8*index. write
// only while no item is in flight. pready is tied high.
// a successful translation runs from acceptance through a check state, 21
// divider steps for the block size ratio, a remainder check, 64 divider
// steps for the partition start, a scale state, 21 shift-add multiply steps,
// a final add and the output load. one quotient or product bit per cycle;
// one divider step serves both divisions. refused requests and zero sizes
// end after the check, other invalid geometry at the remainder or scale
// check, overflow at the scale check, in a multiply step or at the final add.
// reset: registers return to start 0, logical block 512, fs block 4096,
// class unknown, raw writes disallowed; no result is pending.
module fs_block_to_lba_translator_core #(
  parameter int LBA_WIDTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  // apb configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fsblt_pkg::PADDR_W-1:0]  paddr,
  input  logic [fsblt_pkg::PDATA_W-1:0]  pwdata,
  output logic [fsblt_pkg::PDATA_W-1:0]  prdata,
  output logic                           pready,
  // request
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [fsblt_pkg::BLK_W-1:0]    block_num,
  // result
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [LBA_WIDTH-1:0]           lba,
  output logic [1:0]                     status
);
  import fsblt_pkg::*;

  localparam int WIDE_W = START_W + SECTOR_LOG2;

  state_t state, state_next;

  // configuration registers
  logic [START_W-1:0] start_sectors;
  logic [LBB_W-1:0]   logical_block_bytes;
  logic [FBB_W-1:0]   fs_block_bytes;
  logic [CLASS_W-1:0] device_class;
  logic               raw_write_allowed;

  // datapath
  logic [BLK_W-1:0]     blk;
  logic [START_W-1:0]   quo;
  logic [LBB_W-1:0]     rem;
  logic [LBB_W-1:0]     divisor;
  logic [FBB_W-1:0]     ratio;
  logic [LBA_WIDTH-1:0] start_blk;
  logic [LBA_WIDTH-1:0] prod;
  logic [LBA_WIDTH-1:0] res_lba;
  logic [1:0]           res_status;
  logic [CNT_W-1:0]     cnt;

  logic cfg_write;
  logic in_take, out_free;
  logic refuse, geom_zero, last_step;

  // divider step
  logic [LBB_W:0]   rem_sh;
  logic             div_ge;
  logic [LBB_W-1:0] rem_step;

  // gcd(512, lbb) is a power of two: 2^min(9, trailing zeros)
  logic [3:0]       tz;
  logic [3:0]       scale_sh;
  logic [LBB_W-1:0] den;
  logic [WIDE_W-1:0] scaled;
  logic             scale_ovf;

  // shared adder for multiply steps and the final sum
  logic [ADD_W-1:0] add_a, add_b, add_sum;
  logic             add_ovf;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign in_take   = in_valid & ~in_stall;
  assign out_free  = ~out_valid | ~out_stall;
  assign last_step = (cnt == CNT_W'(1));

  assign refuse    = ~raw_write_allowed |
                     ((device_class != CLASS_PLAIN) && (device_class != CLASS_LOOP));
  assign geom_zero = (logical_block_bytes == '0) || (fs_block_bytes == '0);

  assign rem_sh   = {rem, quo[START_W-1]};
  assign div_ge   = rem_sh >= {1'b0, divisor};
  assign rem_step = div_ge ? LBB_W'(rem_sh - {1'b0, divisor}) : rem_sh[LBB_W-1:0];

  always_comb begin
    tz = 4'(SECTOR_LOG2);
    for (int i = SECTOR_LOG2 - 1; i >= 0; i--) begin
      if (logical_block_bytes[i]) begin
        tz = 4'(i);
      end
    end
  end

  assign scale_sh  = 4'(SECTOR_LOG2) - tz;
  assign den       = logical_block_bytes >> tz;
  assign scaled    = {{SECTOR_LOG2{1'b0}}, quo} << scale_sh;
  assign scale_ovf = |scaled[WIDE_W-1:LBA_WIDTH];

  always_comb begin
    if (state == S_SUM) begin
      add_a = {{(ADD_W-LBA_WIDTH){1'b0}}, prod};
      add_b = {{(ADD_W-LBA_WIDTH){1'b0}}, start_blk};
    end else begin
      add_a = {{(ADD_W-LBA_WIDTH-1){1'b0}}, prod, 1'b0};
      add_b = ratio[FBB_W-1] ? {{(ADD_W-BLK_W){1'b0}}, blk} : '0;
    end
  end

  assign add_sum = add_a + add_b;
  assign add_ovf = |add_sum[ADD_W-1:LBA_WIDTH];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_take) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (refuse || geom_zero) state_next = S_DONE;
        else                     state_next = S_RATIO;
      end
      S_RATIO: begin
        if (last_step) state_next = S_RATIO_CHK;
      end
      S_RATIO_CHK: begin
        if (rem != '0) state_next = S_DONE;
        else           state_next = S_START;
      end
      S_START: begin
        if (last_step) state_next = S_SCALE;
      end
      S_SCALE: begin
        if (rem != '0 || scale_ovf) state_next = S_DONE;
        else                        state_next = S_MUL;
      end
      S_MUL: begin
        if (add_ovf || last_step) state_next = (add_ovf) ? S_DONE : S_SUM;
      end
      S_SUM: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_sectors       <= '0;
      logical_block_bytes <= LBB_W'(512);
      fs_block_bytes      <= FBB_W'(4096);
      device_class        <= CLASS_W'(4);
      raw_write_allowed   <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[PADDR_W-1:3])
        REG_START_SECTORS: start_sectors       <= pwdata[START_W-1:0];
        REG_LBB:           logical_block_bytes <= pwdata[LBB_W-1:0];
        REG_FBB:           fs_block_bytes      <= pwdata[FBB_W-1:0];
        REG_DEV_CLASS:     device_class        <= pwdata[CLASS_W-1:0];
        REG_RAW_WRITE:     raw_write_allowed   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[PADDR_W-1:3])
      REG_START_SECTORS: prdata = PDATA_W'(start_sectors);
      REG_LBB:           prdata = PDATA_W'(logical_block_bytes);
      REG_FBB:           prdata = PDATA_W'(fs_block_bytes);
      REG_DEV_CLASS:     prdata = PDATA_W'(device_class);
      REG_RAW_WRITE:     prdata = PDATA_W'(raw_write_allowed);
      default:           prdata = '0;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_take) blk <= block_num;
      end
      S_CHECK: begin
        if (refuse) begin
          res_status <= ST_REFUSED;
        end else if (geom_zero) begin
          res_status <= ST_INVALID;
        end else begin
          // left-align the fs block size so only its bits are walked
          quo     <= {fs_block_bytes, {(START_W-FBB_W){1'b0}}};
          rem     <= '0;
          divisor <= logical_block_bytes;
          cnt     <= RATIO_STEPS;
        end
      end
      S_RATIO, S_START: begin
        quo <= {quo[START_W-2:0], div_ge};
        rem <= rem_step;
        cnt <= cnt - CNT_W'(1);
      end
      S_RATIO_CHK: begin
        if (rem != '0) begin
          res_status <= ST_INVALID;
        end else begin
          ratio   <= quo[FBB_W-1:0];
          quo     <= start_sectors;
          rem     <= '0;
          divisor <= den;
          cnt     <= START_STEPS;
        end
      end
      S_SCALE: begin
        if (rem != '0) begin
          res_status <= ST_INVALID;
        end else if (scale_ovf) begin
          res_status <= ST_OVERFLOW;
        end else begin
          start_blk <= scaled[LBA_WIDTH-1:0];
          prod      <= '0;
          cnt       <= RATIO_STEPS;
        end
      end
      S_MUL: begin
        // msb-first shift-add; product only grows, so any excess is final
        if (add_ovf) begin
          res_status <= ST_OVERFLOW;
        end else begin
          prod  <= add_sum[LBA_WIDTH-1:0];
          ratio <= {ratio[FBB_W-2:0], 1'b0};
          cnt   <= cnt - CNT_W'(1);
        end
      end
      S_SUM: begin
        if (add_ovf) begin
          res_status <= ST_OVERFLOW;
        end else begin
          res_status <= ST_OK;
          res_lba    <= add_sum[LBA_WIDTH-1:0];
        end
      end
      S_DONE: begin
        if (out_free) begin
          status <= res_status;
          lba    <= (res_status == ST_OK) ? res_lba : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: tb/tb_fs_block_to_lba_translator_core.sv
module tb_fs_block_to_lba_translator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fsblt_pkg::*;

  localparam int LBA_W = 64;
  localparam logic [63:0] LBA_MAX = {64{1'b1}} >> (64 - LBA_W);
  localparam logic [63:0] SECTOR_BYTES = 64'd512;
  localparam int RANDOM_ITEMS = 700;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int DRAIN_CYCLES = 120;
  localparam logic [2:0] REG_UNUSED = 3'd6;
  localparam logic [CLASS_W-1:0] CLASS_MAPPER  = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_RAID    = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 3'd4;
  localparam logic [CLASS_W-1:0] CLASS_BAD     = 3'd7;

  class lba_scoreboard;
    typedef struct packed {
      logic [63:0] lba;
      logic [1:0]  status;
    } xlat_t;

    logic [63:0]        start_sectors;
    logic [63:0]        lbb;
    logic [63:0]        fbb;
    logic [CLASS_W-1:0] dev_class;
    logic               raw_ok;
    xlat_t              pending_xlat[$];
    int unsigned        errors;
    int unsigned        requests;
    int unsigned        status_seen[4];

    function new();
      start_sectors = 64'd0;
      lbb = 64'd512;
      fbb = 64'd4096;
      dev_class = CLASS_UNKNOWN;
      raw_ok = 1'b0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        REG_START_SECTORS: start_sectors = val;
        REG_LBB:           lbb = {47'd0, val[LBB_W-1:0]};
        REG_FBB:           fbb = {43'd0, val[FBB_W-1:0]};
        REG_DEV_CLASS:     dev_class = val[CLASS_W-1:0];
        REG_RAW_WRITE:     raw_ok = val[0];
        default: ;
      endcase
    endfunction

    // partition start in logical blocks, scaled through gcd(512, lbb)
    function logic [1:0] convert_start(output logic [63:0] blocks);
      logic [63:0] a, b, r, den, mul, q;
      blocks = 64'd0;
      a = SECTOR_BYTES;
      b = lbb;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      den = lbb / a;
      mul = SECTOR_BYTES / a;
      if (start_sectors % den != 0) return ST_INVALID;
      q = start_sectors / den;
      if (q > LBA_MAX / mul) return ST_OVERFLOW;
      blocks = q * mul;
      return ST_OK;
    endfunction

    function logic [1:0] translate_block(logic [63:0] blk, output logic [63:0] lba);
      logic [63:0] ratio, start_blk, off;
      logic [1:0]  st;
      lba = 64'd0;
      if (!raw_ok) return ST_REFUSED;
      if (dev_class != CLASS_PLAIN && dev_class != CLASS_LOOP) return ST_REFUSED;
      if (lbb == 0 || fbb == 0 || fbb % lbb != 0) return ST_INVALID;
      ratio = fbb / lbb;
      st = convert_start(start_blk);
      if (st != ST_OK) return st;
      if (blk > LBA_MAX / ratio) return ST_OVERFLOW;
      off = blk * ratio;
      if (off > LBA_MAX - start_blk) return ST_OVERFLOW;
      lba = start_blk + off;
      return ST_OK;
    endfunction

    // largest block that still translates under the current geometry
    function logic [63:0] top_block();
      logic [63:0] start_blk;
      if (lbb == 0 || fbb == 0 || fbb % lbb != 0) return LBA_MAX;
      if (convert_start(start_blk) != ST_OK) return LBA_MAX;
      return (LBA_MAX - start_blk) / (fbb / lbb);
    endfunction

    function void note_request(logic [63:0] blk);
      xlat_t want;
      want.status = translate_block(blk, want.lba);
      pending_xlat.push_back(want);
      requests++;
      status_seen[want.status]++;
    endfunction

    function void check_result(logic [63:0] got_lba, logic [1:0] got_status);
      xlat_t want;
      if (pending_xlat.size() == 0) begin
        $error("result with no request outstanding: lba %h status %0d", got_lba, got_status);
        errors++;
        return;
      end
      want = pending_xlat.pop_front();
      if (got_status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, got_status);
        errors++;
      end
      if (got_lba !== want.lba) begin
        $error("lba mismatch: expected %h, got %h", want.lba, got_lba);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [BLK_W-1:0]   block_num = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [LBA_W-1:0]   lba;
  logic [1:0]         status;

  lba_scoreboard sb;
  bit            calm = 1'b0;
  int unsigned   stall_left = 0;
  int unsigned   cycle_count = 0;
  int unsigned   geometries = 0;

  fs_block_to_lba_translator_core #(.LBA_WIDTH(LBA_W)) uut (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .block_num,
    .out_valid, .out_stall, .lba, .status
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    if (roll < 98) return $urandom_range(5, 30);
    return $urandom_range(100, 180);
  endfunction

  // result side: random stall runs, each followed by at least one open cycle
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(lba, status);
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending_xlat.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // psel stays high between back-to-back writes
  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_geometry(input logic [63:0] start_v, input logic [63:0] lbb_v,
                              input logic [63:0] fbb_v, input logic [63:0] cls_v,
                              input logic [63:0] raw_v);
    reg_write(REG_START_SECTORS, start_v);
    reg_write(REG_LBB, lbb_v);
    reg_write(REG_FBB, fbb_v);
    reg_write(REG_DEV_CLASS, cls_v);
    reg_write(REG_RAW_WRITE, raw_v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    geometries++;
  endtask

  task automatic send_block(input logic [63:0] blk);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    block_num <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(blk);
  endtask

  // sender holds off until every outstanding result is back
  task automatic end_burst();
    in_valid <= 1'b0;
    while (sb.pending_xlat.size() != 0) @(posedge clk);
  endtask

  task automatic random_geometry();
    logic [63:0] start_v, lbb_v, kmax, kcap, wide;
    wide = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 65) begin
      // well-formed: permitted class, fbb a multiple of lbb
      if ($urandom_range(0, 3) == 0) lbb_v = 64'($urandom_range(1, 131071));
      else lbb_v = 64'd1 << $urandom_range(0, 16);
      kmax = 64'd2097151 / lbb_v;
      kcap = (kmax < 16) ? kmax : 64'd16;
      case ($urandom_range(0, 3))
        0:       start_v = 64'd0;
        1:       start_v = lbb_v * $urandom_range(0, 100000);
        2:       start_v = lbb_v * (wide >> $urandom_range(17, 63));
        default: start_v = wide;
      endcase
      set_geometry(start_v, lbb_v,
                   lbb_v * (($urandom_range(0, 3) == 0) ? kmax
                                                         : 64'($urandom_range(1, 32'(kcap)))),
                   64'(($urandom_range(0, 1) != 0) ? CLASS_PLAIN : CLASS_LOOP), 64'd1);
    end else begin
      // noise: whole 64-bit words, upper bits must be dropped
      set_geometry(wide,
                   ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom},
                   ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom});
    end
  endtask

  function automatic logic [63:0] random_block();
    logic [63:0] wide, top;
    wide = {$urandom, $urandom};
    top = sb.top_block();
    case ($urandom_range(0, 9))
      0, 1, 2: return 64'($urandom_range(0, 4096));
      3, 4:    return wide;
      5, 6:    return top - $urandom_range(0, 3);
      7:       return top + $urandom_range(1, 2);
      8:       return wide >> $urandom_range(1, 63);
      default: return ($urandom_range(0, 1) != 0) ? 64'd0 : LBA_MAX;
    endcase
  endfunction

  initial begin
    int unsigned sent, burst, i;
    sb = new();
    sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // out of reset raw writes are off
    send_block(64'd0);
    send_block(LBA_MAX);
    end_burst();

    set_geometry(64'd0, 64'd512, 64'd4096, 64'(CLASS_PLAIN), 64'd1);
    send_block(64'd0);
    send_block(64'd1);
    send_block(LBA_MAX / 8);
    send_block(LBA_MAX / 8 + 1);
    end_burst();

    set_geometry(64'd8, 64'd4096, 64'd4096, 64'(CLASS_LOOP), 64'd1);
    send_block(64'd0);
    send_block(sb.top_block());
    send_block(sb.top_block() + 1);
    end_burst();

    // start not on a logical block boundary
    set_geometry(64'd7, 64'd4096, 64'd4096, 64'(CLASS_PLAIN), 64'd1);
    send_block(64'd5);
    end_burst();

    // start scaling to 1-byte blocks overflows
    set_geometry(LBA_MAX, 64'd1, 64'd1, 64'(CLASS_PLAIN), 64'd1);
    send_block(64'd0);
    end_burst();

    set_geometry(64'd0, 64'd0, 64'd4096, 64'(CLASS_PLAIN), 64'd1);
    send_block(64'd3);
    end_burst();
    set_geometry(64'd0, 64'd512, 64'd0, 64'(CLASS_PLAIN), 64'd1);
    send_block(64'd3);
    end_burst();
    set_geometry(64'd0, 64'd4096, 64'd6144, 64'(CLASS_LOOP), 64'd1);
    send_block(64'd3);
    end_burst();

    set_geometry(64'd0, 64'd512, 64'd4096, 64'(CLASS_MAPPER), 64'd1);
    send_block(64'd9);
    end_burst();
    set_geometry(64'd0, 64'd512, 64'd4096, 64'(CLASS_RAID), 64'd1);
    send_block(64'd9);
    end_burst();
    set_geometry(64'd0, 64'd512, 64'd4096, 64'(CLASS_BAD), 64'd1);
    send_block(64'd9);
    end_burst();
    set_geometry(64'd0, 64'd512, 64'd4096, 64'(CLASS_PLAIN), 64'd0);
    send_block(64'd9);
    end_burst();

    set_geometry(LBA_MAX & ~64'd127, 64'd65536, 64'd1048576, 64'(CLASS_LOOP), 64'd1);
    send_block(64'd0);
    send_block(sb.top_block());
    end_burst();

    // write past the register map must be ignored
    reg_write(REG_UNUSED, LBA_MAX);
    set_geometry(64'd393213, 64'd131071, 64'd2097136, 64'(CLASS_PLAIN), 64'd1);
    send_block(64'd2);
    end_burst();

    set_geometry(64'd0, 64'd1, 64'd2097151, 64'(CLASS_PLAIN), 64'd1);
    send_block(sb.top_block());
    send_block(sb.top_block() + 1);
    end_burst();

    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      random_geometry();
      burst = $urandom_range(10, 60);
      for (i = 0; i < burst; i++) send_block(random_block());
      sent += burst;
      end_burst();
    end

    calm = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d translations checked over %0d geometry settings in %0d cycles",
             sb.requests, geometries, cycle_count);
    $display("outcomes: %0d ok, %0d refused, %0d invalid geometry, %0d overflow",
             sb.status_seen[ST_OK], sb.status_seen[ST_REFUSED],
             sb.status_seen[ST_INVALID], sb.status_seen[ST_OVERFLOW]);
    if (sb.errors == 0 && sb.pending_xlat.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/fsblt_pkg.sv
rtl/fs_block_to_lba_translator_core.sv
tb/tb_fs_block_to_lba_translator_core.sv
